/* src/assert_macros.svh */
// Assertion helpers shared by the RTL; every module clocks on clk and resets on arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* src/blpc_pkg.sv */
package blpc_pkg;

	// Register reset values
	localparam logic [14:0] FAST_ON_RST   = 15'd25;
	localparam logic [14:0] FAST_OFF_RST  = 15'd25;
	localparam logic [14:0] SLOW_ON_RST   = 15'd25;
	localparam logic [14:0] SLOW_OFF_RST  = 15'd500;
	localparam logic [14:0] BRIEF_ON_RST  = 15'd15;
	localparam logic [14:0] BRIEF_OFF_RST = 15'd50;
	localparam logic [23:0] TIMEOUT_RST   = 24'd180000;

	// Commands carried by an input item
	typedef enum logic [2:0] {
		CMD_TICK      = 3'd0,
		CMD_SET_MODE  = 3'd1,
		CMD_SET_RED   = 3'd2,
		CMD_SET_GREEN = 3'd3,
		CMD_RESET     = 3'd4,
		CMD_HOLD      = 3'd5
	} cmd_t;

	// Blink modes; codes above the last member drive no LED change
	typedef enum logic [3:0] {
		MODE_ALL_OFF       = 4'd0,
		MODE_RED_OFF       = 4'd1,
		MODE_GREEN_OFF     = 4'd2,
		MODE_RED_FAST      = 4'd3,
		MODE_GREEN_FAST    = 4'd4,
		MODE_RED_SLOW      = 4'd5,
		MODE_GREEN_SLOW    = 4'd6,
		MODE_ALT_SLOW      = 4'd7,
		MODE_ALT_FAST      = 4'd8,
		MODE_BOTH_SLOW     = 4'd9,
		MODE_BOTH_FAST     = 4'd10,
		MODE_RED_CONST     = 4'd11,
		MODE_GREEN_CONST   = 4'd12
	} blink_mode_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_FAST_ON   = 3'd0,
		REG_FAST_OFF  = 3'd1,
		REG_SLOW_ON   = 3'd2,
		REG_SLOW_OFF  = 3'd3,
		REG_BRIEF_ON  = 3'd4,
		REG_BRIEF_OFF = 3'd5,
		REG_TIMEOUT   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [14:0] fast_on_ticks;
		logic [14:0] fast_off_ticks;
		logic [14:0] slow_on_ticks;
		logic [14:0] slow_off_ticks;
		logic [14:0] brief_on_ticks;
		logic [14:0] brief_off_ticks;
		logic [23:0] timeout_ticks;
	} cfg_regs_t;

	typedef struct packed {
		logic [2:0] command;
		logic [3:0] mode;
		logic       restart_timeout;
		logic       level;
	} in_item_t;

	typedef struct packed {
		logic red_lit;
		logic green_lit;
		logic active;
	} out_item_t;

	// Per-LED operation issued by the controller
	typedef enum logic [2:0] {
		LED_NOP,
		LED_TICK,
		LED_DARK,
		LED_SET,
		LED_STOP,
		LED_LOAD
	} led_op_t;

	typedef struct packed {
		led_op_t     op;
		logic [3:0]  mode;
		logic [14:0] on_len;
		logic [14:0] off_len;
		logic        alternate;
		logic        level;
	} led_cmd_t;

endpackage

/* src/blpc_cfg.sv */
module blpc_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	output blpc_pkg::cfg_regs_t regs
);
	import blpc_pkg::*;

	cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Register file; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.fast_on_ticks   <= FAST_ON_RST;
			regs_q.fast_off_ticks  <= FAST_OFF_RST;
			regs_q.slow_on_ticks   <= SLOW_ON_RST;
			regs_q.slow_off_ticks  <= SLOW_OFF_RST;
			regs_q.brief_on_ticks  <= BRIEF_ON_RST;
			regs_q.brief_off_ticks <= BRIEF_OFF_RST;
			regs_q.timeout_ticks   <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FAST_ON:   regs_q.fast_on_ticks   <= cfg_data[14:0];
				REG_FAST_OFF:  regs_q.fast_off_ticks  <= cfg_data[14:0];
				REG_SLOW_ON:   regs_q.slow_on_ticks   <= cfg_data[14:0];
				REG_SLOW_OFF:  regs_q.slow_off_ticks  <= cfg_data[14:0];
				REG_BRIEF_ON:  regs_q.brief_on_ticks  <= cfg_data[14:0];
				REG_BRIEF_OFF: regs_q.brief_off_ticks <= cfg_data[14:0];
				REG_TIMEOUT:   regs_q.timeout_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* src/blpc_led.sv */
module blpc_led (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  blpc_pkg::led_cmd_t cmd,
	output logic               level,
	output logic [3:0]         last_mode
);
	import blpc_pkg::*;

	logic [14:0]        on_len_q, off_len_q;
	logic signed [15:0] cnt_q;
	logic               en_q, lvl_q;
	logic [3:0]         last_mode_q;

	logic signed [15:0] on16, off16, cmd_on16;
	logic signed [15:0] cnt_step, cnt_tick;
	logic               lvl_tick;

	assign on16     = signed'({1'b0, on_len_q});
	assign off16    = signed'({1'b0, off_len_q});
	assign cmd_on16 = signed'({1'b0, cmd.on_len});

	// One tick of the phase counter: count toward +/-1, then reload
	always_comb begin
		lvl_tick = lvl_q;
		cnt_step = cnt_q;
		cnt_tick = cnt_q;
		if (cnt_q != 16'sd0) begin
			if (cnt_q > 16'sd1) begin
				lvl_tick = 1'b1;
				cnt_step = cnt_q - 16'sd1;
			end else if (cnt_q < -16'sd1) begin
				lvl_tick = 1'b0;
				cnt_step = cnt_q + 16'sd1;
			end
			if (cnt_step == 16'sd1) begin
				cnt_tick = (off_len_q != '0) ? -off16 : on16;
			end else if (cnt_step == -16'sd1) begin
				cnt_tick = on16;
			end else begin
				cnt_tick = cnt_step;
			end
		end else if (en_q) begin
			lvl_tick = 1'b0;
		end
	end

	// LED state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_len_q    <= '0;
			off_len_q   <= '0;
			cnt_q       <= '0;
			en_q        <= 1'b0;
			lvl_q       <= 1'b0;
			last_mode_q <= '0;
		end else if (upd) begin
			unique case (cmd.op)
				LED_NOP: ;
				LED_TICK: begin
					cnt_q <= cnt_tick;
					lvl_q <= lvl_tick;
				end
				LED_DARK: lvl_q <= 1'b0;
				LED_SET:  lvl_q <= cmd.level;
				LED_STOP: begin
					last_mode_q <= cmd.mode;
					lvl_q       <= 1'b0;
					cnt_q       <= '0;
					en_q        <= 1'b0;
				end
				LED_LOAD: begin
					last_mode_q <= cmd.mode;
					on_len_q    <= cmd.on_len;
					off_len_q   <= cmd.off_len;
					cnt_q       <= cmd.alternate ? -cmd_on16 : cmd_on16;
					en_q        <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign level     = lvl_q;
	assign last_mode = last_mode_q;

	`include "assert_macros.svh"

	// A stopped LED never has a phase running
	`ASSERT_CLK(a_stopped_idle, !en_q |-> cnt_q == 16'sd0, "phase counter runs while LED is stopped")

endmodule

/* src/blpc_ctrl.sv */
module blpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  blpc_pkg::in_item_t  item,
	input  blpc_pkg::cfg_regs_t cfg,
	input  logic [3:0]          red_last,
	input  logic [3:0]          green_last,
	output blpc_pkg::led_cmd_t  red_cmd,
	output blpc_pkg::led_cmd_t  green_cmd,
	output logic                active
);
	import blpc_pkg::*;

	logic [23:0] tl_q, tl_d, tl_eff;
	logic        held_q, held_d;
	logic [3:0]  last_mode_q, last_mode_d;
	logic        force_off, run;

	function automatic led_cmd_t mk_cmd(led_op_t op, logic [3:0] m, logic [14:0] on,
	                                    logic [14:0] off, logic alt, logic lv);
		led_cmd_t c;
		c.op        = op;
		c.mode      = m;
		c.on_len    = on;
		c.off_len   = off;
		c.alternate = alt;
		c.level     = lv;
		return c;
	endfunction

	assign tl_eff = item.restart_timeout ? cfg.timeout_ticks : tl_q;

	// Command decode and next state
	always_comb begin
		tl_d        = tl_q;
		held_d      = held_q;
		last_mode_d = last_mode_q;
		red_cmd     = mk_cmd(LED_NOP, '0, '0, '0, 1'b0, 1'b0);
		green_cmd   = mk_cmd(LED_NOP, '0, '0, '0, 1'b0, 1'b0);
		force_off   = 1'b0;
		run         = 1'b0;
		unique case (item.command)
			CMD_TICK: begin
				tl_d      = (tl_q != '0) ? tl_q - 24'd1 : tl_q;
				force_off = (tl_d == '0) && ((tl_q != '0) || !held_q);
				run       = !held_q && (tl_d != '0);
				if (force_off) begin
					red_cmd.op   = LED_DARK;
					green_cmd.op = LED_DARK;
				end else if (run) begin
					red_cmd.op   = LED_TICK;
					green_cmd.op = LED_TICK;
				end
			end
			CMD_SET_MODE: begin
				tl_d = tl_eff;
				if (!(tl_eff == '0 && item.mode != MODE_ALL_OFF)) begin
					last_mode_d = item.mode;
					if (item.mode != last_mode_q) begin
						unique case (item.mode) inside
							MODE_ALL_OFF: begin
								red_cmd   = mk_cmd(LED_STOP, MODE_ALL_OFF, '0, '0, 1'b0, 1'b0);
								green_cmd = mk_cmd(LED_STOP, MODE_ALL_OFF, '0, '0, 1'b0, 1'b0);
							end
							MODE_RED_OFF: begin
								if (red_last != MODE_RED_OFF)
									red_cmd = mk_cmd(LED_STOP, item.mode, '0, '0, 1'b0, 1'b0);
							end
							MODE_GREEN_OFF: begin
								if (green_last != MODE_GREEN_OFF)
									green_cmd = mk_cmd(LED_STOP, item.mode, '0, '0, 1'b0, 1'b0);
							end
							MODE_RED_FAST, MODE_RED_SLOW, MODE_RED_CONST: begin
								if (red_last != item.mode) begin
									held_d = 1'b0;
									if (item.mode == MODE_RED_FAST)
										red_cmd = mk_cmd(LED_LOAD, item.mode, cfg.brief_on_ticks,
										                 cfg.brief_off_ticks, 1'b0, 1'b0);
									else if (item.mode == MODE_RED_SLOW)
										red_cmd = mk_cmd(LED_LOAD, item.mode, cfg.slow_on_ticks,
										                 cfg.slow_off_ticks, 1'b0, 1'b0);
									else
										red_cmd = mk_cmd(LED_LOAD, item.mode, cfg.slow_on_ticks,
										                 '0, 1'b0, 1'b0);
								end
							end
							MODE_GREEN_FAST, MODE_GREEN_SLOW, MODE_GREEN_CONST: begin
								if (green_last != item.mode) begin
									held_d = 1'b0;
									if (item.mode == MODE_GREEN_FAST)
										green_cmd = mk_cmd(LED_LOAD, item.mode, cfg.brief_on_ticks,
										                   cfg.brief_off_ticks, 1'b0, 1'b0);
									else if (item.mode == MODE_GREEN_SLOW)
										green_cmd = mk_cmd(LED_LOAD, item.mode, cfg.slow_on_ticks,
										                   cfg.slow_off_ticks, 1'b0, 1'b0);
									else
										green_cmd = mk_cmd(LED_LOAD, item.mode, cfg.slow_on_ticks,
										                   '0, 1'b0, 1'b0);
								end
							end
							MODE_ALT_SLOW, MODE_ALT_FAST, MODE_BOTH_SLOW, MODE_BOTH_FAST: begin
								if (red_last != item.mode || green_last != item.mode) begin
									held_d = 1'b0;
									if (item.mode == MODE_ALT_SLOW || item.mode == MODE_BOTH_SLOW) begin
										red_cmd   = mk_cmd(LED_LOAD, item.mode, cfg.slow_on_ticks,
										                   cfg.slow_off_ticks, 1'b0, 1'b0);
										green_cmd = mk_cmd(LED_LOAD, item.mode, cfg.slow_on_ticks,
										                   cfg.slow_off_ticks,
										                   item.mode == MODE_ALT_SLOW, 1'b0);
									end else begin
										red_cmd   = mk_cmd(LED_LOAD, item.mode, cfg.fast_on_ticks,
										                   cfg.fast_off_ticks, 1'b0, 1'b0);
										green_cmd = mk_cmd(LED_LOAD, item.mode, cfg.fast_on_ticks,
										                   cfg.fast_off_ticks,
										                   item.mode == MODE_ALT_FAST, 1'b0);
									end
								end
							end
							default: ;
						endcase
					end
				end
			end
			CMD_SET_RED: begin
				if (tl_q != '0)
					red_cmd = mk_cmd(LED_SET, '0, '0, '0, 1'b0, item.level);
			end
			CMD_SET_GREEN: begin
				if (tl_q != '0)
					green_cmd = mk_cmd(LED_SET, '0, '0, '0, 1'b0, item.level);
			end
			CMD_RESET: begin
				if (last_mode_q != MODE_ALL_OFF) begin
					red_cmd   = mk_cmd(LED_STOP, MODE_ALL_OFF, '0, '0, 1'b0, 1'b0);
					green_cmd = mk_cmd(LED_STOP, MODE_ALL_OFF, '0, '0, 1'b0, 1'b0);
				end
				last_mode_d = MODE_ALL_OFF;
				held_d      = 1'b0;
				tl_d        = cfg.timeout_ticks;
			end
			CMD_HOLD: begin
				if (tl_q != '0)
					held_d = 1'b1;
			end
			default: ;
		endcase
	end

	// Timeout, hold and mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q        <= TIMEOUT_RST;
			held_q      <= 1'b0;
			last_mode_q <= MODE_ALL_OFF;
		end else if (upd) begin
			tl_q        <= tl_d;
			held_q      <= held_d;
			last_mode_q <= last_mode_d;
		end
	end

	assign active = (tl_q != '0);

	`include "assert_macros.svh"

	// Hold is only taken while the timeout runs, and a hold leaves the timeout alone
	`ASSERT_CLK(a_hold_active, $rose(held_q) |-> tl_q != '0, "hold with expired timeout")
	// A tick on a running timeout counts it down by exactly one
	`ASSERT_CLK(a_tick_dec, (upd && item.command == CMD_TICK && tl_q != '0) |=>
		tl_q == $past(tl_q) - 24'd1, "timeout missed a tick")

endmodule

/* src/two_led_blink_pattern_controller.sv */
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// in       | in_valid / in_ready   | in_item  (command, mode, restart, level)
// out      | out_valid / out_ready | out_item (red_lit, green_lit, active)
// cfg      | cfg_valid / cfg_ready | cfg_index (3 bits), cfg_data (24 bits)
//
// One item per cycle while out_ready holds: an accepted item is registered in
// the input register, then the controller and LED logic update the state.
// The result is read straight from the state registers.
// Reset (arst_n low) loads the register defaults and clears all LED state.
// A stalled result freezes the state; the input register still takes one item.
module two_led_blink_pattern_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  blpc_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output blpc_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	import blpc_pkg::*;

	logic      in_valid_s1;
	in_item_t  in_item_s1;
	logic      out_valid_q;
	logic      advance;
	cfg_regs_t regs;
	led_cmd_t  red_cmd, green_cmd;
	logic      red_level, green_level, active;
	logic [3:0] red_last, green_last;

	// An item moves into the state whenever the result slot is free or drains
	assign advance  = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_item_s1 <= in_item;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	blpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	blpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (advance),
		.item       (in_item_s1),
		.cfg        (regs),
		.red_last   (red_last),
		.green_last (green_last),
		.red_cmd    (red_cmd),
		.green_cmd  (green_cmd),
		.active     (active)
	);

	blpc_led u_red (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (advance),
		.cmd       (red_cmd),
		.level     (red_level),
		.last_mode (red_last)
	);

	blpc_led u_green (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (advance),
		.cmd       (green_cmd),
		.level     (green_level),
		.last_mode (green_last)
	);

	assign out_valid          = out_valid_q;
	assign out_item.red_lit   = red_level;
	assign out_item.green_lit = green_level;
	assign out_item.active    = active;

	`include "assert_macros.svh"

	// Every item moved into the state produces a result next cycle
	`ASSERT_CLK(a_adv_result, advance |=> out_valid, "processed item gave no result")
	// A waiting item in the input register is never dropped
	`ASSERT_CLK(a_s1_kept, (in_valid_s1 && !advance) |=> in_valid_s1, "input item lost while stalled")

endmodule

/* tb/sv/led_pattern_checker.sv */
`timescale 1ns / 1ps

module led_pattern_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  blpc_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  blpc_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	output int                  errors,
	output int                  outstanding
);
	import blpc_pkg::*;

	localparam int RED   = 0;
	localparam int GREEN = 1;

	// Timing state of one LED; cnt > 0 is the on phase, cnt < 0 the off phase
	typedef struct packed {
		logic [3:0]         mode;
		logic [14:0]        on_len;
		logic [14:0]        off_len;
		logic signed [15:0] cnt;
		logic               en;
		logic               lvl;
	} led_state_t;

	cfg_regs_t   regs;
	logic [23:0] timeout_left;
	logic        held;
	logic [3:0]  last_mode;
	led_state_t  leds [2];
	out_item_t   expected_leds [$];

	function automatic logic signed [15:0] as_count(logic [14:0] len);
		return $signed({1'b0, len});
	endfunction

	// One tick of a single LED's phase counter
	function automatic led_state_t advance_led(led_state_t s);
		logic signed [15:0] c;
		c = s.cnt;
		if (c != 16'sd0) begin
			if (c > 16'sd1) begin
				s.lvl = 1'b1;
				c = c - 16'sd1;
			end else if (c < -16'sd1) begin
				s.lvl = 1'b0;
				c = c + 16'sd1;
			end
			// end of phase: on goes to off (or stays on), off goes to on
			if (c == 16'sd1)
				c = (s.off_len != 15'd0) ? -as_count(s.off_len) : as_count(s.on_len);
			else if (c == -16'sd1)
				c = as_count(s.on_len);
			s.cnt = c;
		end else if (s.en) begin
			s.lvl = 1'b0;
		end
		return s;
	endfunction

	task automatic load_led(input int idx, input logic [3:0] m,
			input logic [14:0] on_len, input logic [14:0] off_len);
		if (leds[idx].mode != m) begin
			leds[idx].mode    = m;
			leds[idx].on_len  = on_len;
			leds[idx].off_len = off_len;
			leds[idx].cnt     = as_count(on_len);
			leds[idx].en      = 1'b1;
			held              = 1'b0;
		end
	endtask

	// Both LEDs share the lengths; alternating starts green in its off phase
	task automatic load_pair(input logic [3:0] m, input logic [14:0] on_len,
			input logic [14:0] off_len, input logic alternate);
		if (leds[RED].mode != m || leds[GREEN].mode != m) begin
			for (int i = 0; i < 2; i++) begin
				leds[i].mode    = m;
				leds[i].on_len  = on_len;
				leds[i].off_len = off_len;
				leds[i].cnt     = as_count(on_len);
				leds[i].en      = 1'b1;
			end
			if (alternate)
				leds[GREEN].cnt = -as_count(on_len);
			held = 1'b0;
		end
	endtask

	task automatic set_blink_mode(input logic [3:0] m, input logic restart);
		if (restart)
			timeout_left = regs.timeout_ticks;
		// expired timeout only lets all-off through
		if (timeout_left == 24'd0 && m != MODE_ALL_OFF)
			return;
		if (m != last_mode) begin
			case (m)
				MODE_ALL_OFF: begin
					for (int i = 0; i < 2; i++) begin
						leds[i].mode = MODE_ALL_OFF;
						leds[i].cnt  = 16'sd0;
						leds[i].lvl  = 1'b0;
						leds[i].en   = 1'b0;
					end
				end
				MODE_RED_OFF: begin
					if (leds[RED].mode != MODE_RED_OFF) begin
						leds[RED].mode = MODE_RED_OFF;
						leds[RED].lvl  = 1'b0;
						leds[RED].cnt  = 16'sd0;
						leds[RED].en   = 1'b0;
					end
				end
				MODE_GREEN_OFF: begin
					if (leds[GREEN].mode != MODE_GREEN_OFF) begin
						leds[GREEN].mode = MODE_GREEN_OFF;
						leds[GREEN].lvl  = 1'b0;
						leds[GREEN].cnt  = 16'sd0;
						leds[GREEN].en   = 1'b0;
					end
				end
				MODE_RED_FAST:
					load_led(RED, m, regs.brief_on_ticks, regs.brief_off_ticks);
				MODE_GREEN_FAST:
					load_led(GREEN, m, regs.brief_on_ticks, regs.brief_off_ticks);
				MODE_RED_SLOW:
					load_led(RED, m, regs.slow_on_ticks, regs.slow_off_ticks);
				MODE_GREEN_SLOW:
					load_led(GREEN, m, regs.slow_on_ticks, regs.slow_off_ticks);
				MODE_ALT_SLOW:
					load_pair(m, regs.slow_on_ticks, regs.slow_off_ticks, 1'b1);
				MODE_ALT_FAST:
					load_pair(m, regs.fast_on_ticks, regs.fast_off_ticks, 1'b1);
				MODE_BOTH_SLOW:
					load_pair(m, regs.slow_on_ticks, regs.slow_off_ticks, 1'b0);
				MODE_BOTH_FAST:
					load_pair(m, regs.fast_on_ticks, regs.fast_off_ticks, 1'b0);
				MODE_RED_CONST:
					load_led(RED, m, regs.slow_on_ticks, 15'd0);
				MODE_GREEN_CONST:
					load_led(GREEN, m, regs.slow_on_ticks, 15'd0);
				default: ;
			endcase
		end
		last_mode = m;
	endtask

	task automatic count_tick();
		if (timeout_left != 24'd0) begin
			timeout_left = timeout_left - 24'd1;
			if (timeout_left == 24'd0) begin
				leds[RED].lvl   = 1'b0;
				leds[GREEN].lvl = 1'b0;
			end
		end
		if (!held) begin
			if (timeout_left != 24'd0) begin
				leds[RED]   = advance_led(leds[RED]);
				leds[GREEN] = advance_led(leds[GREEN]);
			end else begin
				leds[RED].lvl   = 1'b0;
				leds[GREEN].lvl = 1'b0;
			end
		end
	endtask

	// Apply one command to the local state and return the LED levels it leaves
	task automatic predict_leds(input in_item_t item, output out_item_t res);
		case (item.command)
			CMD_TICK:
				count_tick();
			CMD_SET_MODE:
				set_blink_mode(item.mode, item.restart_timeout);
			CMD_SET_RED:
				if (timeout_left != 24'd0) leds[RED].lvl = item.level;
			CMD_SET_GREEN:
				if (timeout_left != 24'd0) leds[GREEN].lvl = item.level;
			CMD_RESET: begin
				set_blink_mode(MODE_ALL_OFF, 1'b0);
				held         = 1'b0;
				timeout_left = regs.timeout_ticks;
			end
			CMD_HOLD:
				if (timeout_left != 24'd0) held = 1'b1;
			default: ;
		endcase
		res.red_lit   = leds[RED].lvl;
		res.green_lit = leds[GREEN].lvl;
		res.active    = (timeout_left != 24'd0);
	endtask

	task automatic report_field(input string field, input logic want, input logic got);
		errors++;
		$display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
	endtask

	// Channel monitor: result compare, register writes, new predictions
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t pred;
		if (!arst_n) begin
			regs.fast_on_ticks   = FAST_ON_RST;
			regs.fast_off_ticks  = FAST_OFF_RST;
			regs.slow_on_ticks   = SLOW_ON_RST;
			regs.slow_off_ticks  = SLOW_OFF_RST;
			regs.brief_on_ticks  = BRIEF_ON_RST;
			regs.brief_off_ticks = BRIEF_OFF_RST;
			regs.timeout_ticks   = TIMEOUT_RST;
			timeout_left         = TIMEOUT_RST;
			held                 = 1'b0;
			last_mode            = MODE_ALL_OFF;
			leds[RED]            = '0;
			leds[GREEN]          = '0;
			expected_leds.delete();
			errors               = 0;
			outstanding          = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_leds.size() == 0) begin
					errors++;
					$display("%0t: result transfer with nothing expected, expected none, actual %b",
						$time, out_item);
				end else begin
					want = expected_leds.pop_front();
					if (out_item.red_lit !== want.red_lit)
						report_field("red_lit", want.red_lit, out_item.red_lit);
					if (out_item.green_lit !== want.green_lit)
						report_field("green_lit", want.green_lit, out_item.green_lit);
					if (out_item.active !== want.active)
						report_field("active", want.active, out_item.active);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FAST_ON:   regs.fast_on_ticks   = cfg_data[14:0];
					REG_FAST_OFF:  regs.fast_off_ticks  = cfg_data[14:0];
					REG_SLOW_ON:   regs.slow_on_ticks   = cfg_data[14:0];
					REG_SLOW_OFF:  regs.slow_off_ticks  = cfg_data[14:0];
					REG_BRIEF_ON:  regs.brief_on_ticks  = cfg_data[14:0];
					REG_BRIEF_OFF: regs.brief_off_ticks = cfg_data[14:0];
					REG_TIMEOUT:   regs.timeout_ticks   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_leds(in_item, pred);
				expected_leds.push_back(pred);
			end
			outstanding = expected_leds.size();
		end
	end

endmodule

/* tb/sv/two_led_blink_pattern_controller_tb.sv */
`timescale 1ns / 1ps

module two_led_blink_pattern_controller_tb;
	import blpc_pkg::*;

	// Codes the package leaves unnamed
	localparam logic [2:0] CMD_SPARE_LO  = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
	localparam logic [3:0] MODE_SPARE_LO = 4'd13;
	localparam logic [3:0] MODE_SPARE_HI = 4'd15;
	localparam logic [2:0] REG_SPARE     = 3'd7;

	localparam int IDLE_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	int errors;
	int outstanding;
	int idle_cycles = 0;
	bit calm;

	two_led_blink_pattern_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	led_pattern_checker u_led_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic in_item_t make_item(input logic [2:0] cmd, input logic [3:0] mode,
			input logic restart, input logic level);
		in_item_t it;
		it.command         = cmd;
		it.mode            = mode;
		it.restart_timeout = restart;
		it.level           = level;
		return it;
	endfunction

	// Mostly ticks and mode changes, with some of everything else
	function automatic in_item_t random_item();
		int pick;
		logic [2:0] cmd;
		pick = $urandom_range(0, 99);
		if (pick < 35)      cmd = CMD_TICK;
		else if (pick < 60) cmd = CMD_SET_MODE;
		else if (pick < 70) cmd = CMD_SET_RED;
		else if (pick < 80) cmd = CMD_SET_GREEN;
		else if (pick < 87) cmd = CMD_RESET;
		else if (pick < 95) cmd = CMD_HOLD;
		else if (pick < 97) cmd = CMD_SPARE_LO;
		else                cmd = CMD_SPARE_HI;
		return make_item(cmd, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	// Length value with junk in the data bits above the 15-bit field
	function automatic logic [23:0] length_word(input int lo, input int hi);
		return 24'(($urandom() & 32'h00FF_8000) | 32'($urandom_range(hi, lo)));
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic push_item(input in_item_t item);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_item  = item;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic program_lengths(input int lo, input int hi, input logic [23:0] reload);
		write_reg(REG_FAST_ON,   length_word(lo, hi));
		write_reg(REG_FAST_OFF,  length_word(lo, hi));
		write_reg(REG_SLOW_ON,   length_word(lo, hi));
		write_reg(REG_SLOW_OFF,  length_word(lo, hi));
		write_reg(REG_BRIEF_ON,  length_word(lo, hi));
		write_reg(REG_BRIEF_OFF, length_word(lo, hi));
		write_reg(REG_TIMEOUT,   reload);
	endtask

	// Stop sending and wait until every predicted result has been seen
	task automatic drain_results();
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// Mode change followed by a run of ticks, mixed with single random commands
	task automatic run_random(input int count);
		int sent;
		int run_len;
		sent = 0;
		while (sent < count) begin
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 7) begin
				push_item(make_item(CMD_SET_MODE, 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
				run_len = $urandom_range(3, 20);
				repeat (run_len) begin
					if ($urandom_range(0, 7) == 0)
						push_item(random_item());
					else
						push_item(make_item(CMD_TICK, 4'($urandom_range(0, 15)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
				end
				sent += run_len + 1;
			end else begin
				push_item(random_item());
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	// Result side: a random stall before each transfer
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 14);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("[two_led_blink_pattern_controller] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		calm      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: direct levels, repeated mode, every mode but all-off, spare codes, hold
		push_item(make_item(CMD_TICK,      MODE_ALL_OFF,     1'b0, 1'b0));
		push_item(make_item(CMD_SET_RED,   MODE_ALL_OFF,     1'b0, 1'b1));
		push_item(make_item(CMD_SET_GREEN, MODE_ALL_OFF,     1'b0, 1'b1));
		push_item(make_item(CMD_TICK,      MODE_ALL_OFF,     1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_RED_FAST,    1'b1, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_RED_FAST,    1'b0, 1'b0));
		push_item(make_item(CMD_TICK,      MODE_ALL_OFF,     1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_GREEN_CONST, 1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_ALT_SLOW,    1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_ALT_FAST,    1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_BOTH_SLOW,   1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_BOTH_FAST,   1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_RED_SLOW,    1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_GREEN_SLOW,  1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_GREEN_FAST,  1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_RED_CONST,   1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_RED_OFF,     1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_GREEN_OFF,   1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_SPARE_LO,    1'b1, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_SPARE_HI,    1'b0, 1'b1));
		push_item(make_item(CMD_HOLD,      MODE_ALL_OFF,     1'b0, 1'b0));
		push_item(make_item(CMD_TICK,      MODE_ALL_OFF,     1'b0, 1'b0));
		push_item(make_item(CMD_SPARE_LO,  MODE_SPARE_HI,    1'b1, 1'b1));
		push_item(make_item(CMD_SPARE_HI,  MODE_ALL_OFF,     1'b0, 1'b0));
		push_item(make_item(CMD_RESET,     MODE_ALL_OFF,     1'b0, 1'b0));
		run_random(120);
		drain_results();

		// Short periods and timeout: phases wrap and the timeout expires often
		program_lengths(1, 4, 24'($urandom_range(20, 60)));
		run_random(150);
		drain_results();

		// Longest periods and timeout
		program_lengths(32767, 32767, 24'hFF_FFFF);
		run_random(80);
		drain_results();

		// Zero timeout reload: everything stays expired
		program_lengths(0, 1, 24'd0);
		push_item(make_item(CMD_RESET,     MODE_ALL_OFF,  1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_RED_FAST, 1'b1, 1'b0));
		push_item(make_item(CMD_SET_RED,   MODE_ALL_OFF,  1'b0, 1'b1));
		push_item(make_item(CMD_HOLD,      MODE_ALL_OFF,  1'b0, 1'b0));
		push_item(make_item(CMD_TICK,      MODE_ALL_OFF,  1'b0, 1'b0));
		push_item(make_item(CMD_SET_MODE,  MODE_ALL_OFF,  1'b0, 1'b0));
		drain_results();

		// On lengths of zero and one; the spare register index must be ignored
		write_reg(REG_TIMEOUT, 24'($urandom_range(6, 30)));
		write_reg(REG_SPARE, 24'($urandom()));
		run_random(150);
		drain_results();

		// Mixed small settings
		program_lengths(0, 6, 24'($urandom_range(5, 80)));
		run_random(200);
		drain_results();

		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("[two_led_blink_pattern_controller] OK");
		else
			$display("[two_led_blink_pattern_controller] ERROR");
		$finish;
	end

endmodule
